/* hw/rtl/slpe_pkg.sv */
// Shared constants, codes and types of the sorted list pool engine.
package slpe_pkg;

  localparam int POOL_DEPTH_DEF = 16;
  localparam int VALUE_W        = 32;
  localparam int IDX_OUT_W      = 6;

  localparam logic [1:0] ACT_INSERT   = 2'd0;
  localparam logic [1:0] ACT_DELETE   = 2'd1;
  localparam logic [1:0] ACT_TRAVERSE = 2'd2;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DELETED   = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_ENTRY     = 3'd5,
    ST_EMPTY     = 3'd6
  } status_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

/* hw/rtl/slpe_cmp.sv */
// Shared signed compare unit used by the insert and delete list walk steps.
module slpe_cmp import slpe_pkg::*; (
  input  logic signed [VALUE_W-1:0] a,
  input  logic signed [VALUE_W-1:0] b,
  output cmp_res_t                  res
);

  // Report a < b (signed) and a == b.
  always_comb begin
    res.lt = (a < b);
    res.eq = (a == b);
  end

endmodule

/* hw/rtl/slpe_pool.sv */
// Entry pool: value memory and link memory with reset-value tracking.
module slpe_pool import slpe_pkg::*; #(
  parameter int POOL_DEPTH = POOL_DEPTH_DEF,
  parameter int IW         = $clog2(POOL_DEPTH)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [IW-1:0]             rd_addr,
  output logic signed [VALUE_W-1:0] rd_value,
  output logic [IW-1:0]             rd_link,
  output logic                      rd_null,
  input  logic                      val_we,
  input  logic [IW-1:0]             val_waddr,
  input  logic signed [VALUE_W-1:0] val_wdata,
  input  logic                      link_we,
  input  logic [IW-1:0]             link_waddr,
  input  logic                      link_wnull,
  input  logic [IW-1:0]             link_widx
);

  logic signed [VALUE_W-1:0] vmem [POOL_DEPTH];
  logic [IW:0]               lmem [POOL_DEPTH];
  logic [POOL_DEPTH-1:0]     lvalid;

  logic [IW:0]   rd_lword;
  logic          rd_lvalid;
  logic [IW-1:0] rd_addr_q;

  always_ff @(posedge clk) begin
    if (val_we) begin
      vmem[val_waddr] <= val_wdata;
    end
    if (link_we) begin
      lmem[link_waddr] <= {link_wnull, link_widx};
    end
    rd_value  <= vmem[rd_addr];
    rd_lword  <= lmem[rd_addr];
    rd_lvalid <= lvalid[rd_addr];
    rd_addr_q <= rd_addr;
  end

  // Mark link entries once written; an unwritten one reads as its reset chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      lvalid <= '0;
    end else if (link_we) begin
      lvalid[link_waddr] <= 1'b1;
    end
  end

  always_comb begin
    if (rd_lvalid) begin
      rd_null = rd_lword[IW];
      rd_link = rd_lword[IW-1:0];
    end else if (rd_addr_q == IW'(POOL_DEPTH - 1)) begin
      rd_null = 1'b1;
      rd_link = '0;
    end else begin
      rd_null = 1'b0;
      rd_link = rd_addr_q + IW'(1);
    end
  end

endmodule

/* hw/rtl/sorted_list_pool_engine.sv */
// Top level: sequencer of the sorted linked list kept in a fixed entry pool.
//
//  channel   direction  transfer mark          payload
//  -------   ---------  ---------------------  ------------------------------------
//  command   in         start && !busy         action, item_value
//  result    out        result_valid (1 cycle) status, entry_value, entry_index,
//                                              next_index, next_is_null, last_result
//
// Steps: one pool read per list step; insert and delete steps feed it to the shared
// compare unit. Insert takes a free-list entry (S_INS_FREE), reads one entry per
// step in S_INS_HEAD and S_INS_WALK, then links in S_INS_LINK past the head; delete
// reads in S_DEL_HEAD and S_DEL_WALK, plus S_DEL_FREE on a match past the head;
// traverse one S_TRV step per entry. Overflow, underflow, empty never raise busy.
// Reset (rst, synchronous) empties the list, chains all entries free; no stall.
module sorted_list_pool_engine import slpe_pkg::*; #(
  parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  action,
  input  logic signed [VALUE_W-1:0]   item_value,
  output logic                        result_valid,
  output logic [2:0]                  status,
  output logic signed [VALUE_W-1:0]   entry_value,
  output logic [IDX_OUT_W-1:0]        entry_index,
  output logic [IDX_OUT_W-1:0]        next_index,
  output logic                        next_is_null,
  output logic                        last_result
);

  localparam int IW = $clog2(POOL_DEPTH);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_INS_FREE = 9'b000000010,
    S_INS_HEAD = 9'b000000100,
    S_INS_WALK = 9'b000001000,
    S_INS_LINK = 9'b000010000,
    S_DEL_HEAD = 9'b000100000,
    S_DEL_WALK = 9'b001000000,
    S_DEL_FREE = 9'b010000000,
    S_TRV      = 9'b100000000
  } state_t;

  state_t state, state_next;

  // Operation context.
  logic signed [VALUE_W-1:0] item, item_next;
  logic [IW-1:0] loc, loc_next;     // entry taken from the free list
  logic [IW-1:0] prev, prev_next;   // entry before the walk position
  logic [IW-1:0] cur, cur_next;     // entry whose read data arrives now

  // List heads.
  logic [IW-1:0] list_head, list_head_next;
  logic          list_null, list_null_next;
  logic [IW-1:0] free_head, free_head_next;
  logic          free_null, free_null_next;

  // Pool port.
  logic [IW-1:0]             rd_addr;
  logic signed [VALUE_W-1:0] rd_value;
  logic [IW-1:0]             rd_link;
  logic                      rd_null;
  logic                      val_we;
  logic                      link_we;
  logic [IW-1:0]             link_waddr;
  logic                      link_wnull;
  logic [IW-1:0]             link_widx;

  cmp_res_t cmp;

  // Result staged for the output register.
  logic                      emit;
  status_t                   emit_status;
  logic signed [VALUE_W-1:0] emit_value;
  logic [IW-1:0]             emit_index;
  logic [IW-1:0]             emit_next;
  logic                      emit_null;
  logic                      emit_last;

  slpe_pool #(
    .POOL_DEPTH (POOL_DEPTH),
    .IW         (IW)
  ) u_pool (
    .clk        (clk),
    .rst        (rst),
    .rd_addr    (rd_addr),
    .rd_value   (rd_value),
    .rd_link    (rd_link),
    .rd_null    (rd_null),
    .val_we     (val_we),
    .val_waddr  (loc),
    .val_wdata  (item),
    .link_we    (link_we),
    .link_waddr (link_waddr),
    .link_wnull (link_wnull),
    .link_widx  (link_widx)
  );

  // Compare the held item against the entry just read.
  slpe_cmp u_cmp (
    .a   (item),
    .b   (rd_value),
    .res (cmp)
  );

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    item_next      = item;
    loc_next       = loc;
    prev_next      = prev;
    cur_next       = cur;
    list_head_next = list_head;
    list_null_next = list_null;
    free_head_next = free_head;
    free_null_next = free_null;

    rd_addr    = cur;
    val_we     = 1'b0;
    link_we    = 1'b0;
    link_waddr = loc;
    link_wnull = 1'b0;
    link_widx  = '0;

    emit        = 1'b0;
    emit_status = ST_INSERTED;
    emit_value  = '0;
    emit_index  = '0;
    emit_next   = '0;
    emit_null   = 1'b0;
    emit_last   = 1'b1;

    case (state)
      S_IDLE: begin
        if (start) begin
          item_next = item_value;
          case (action)
            ACT_INSERT: begin
              if (free_null) begin
                emit        = 1'b1;
                emit_status = ST_OVERFLOW;
              end else begin
                // Take the free-list head and fetch its link.
                loc_next   = free_head;
                rd_addr    = free_head;
                state_next = S_INS_FREE;
              end
            end
            ACT_DELETE: begin
              if (list_null) begin
                emit        = 1'b1;
                emit_status = ST_UNDERFLOW;
              end else begin
                cur_next   = list_head;
                rd_addr    = list_head;
                state_next = S_DEL_HEAD;
              end
            end
            ACT_TRAVERSE: begin
              if (list_null) begin
                emit        = 1'b1;
                emit_status = ST_EMPTY;
              end else begin
                cur_next   = list_head;
                rd_addr    = list_head;
                state_next = S_TRV;
              end
            end
            default: begin
              // Drop the unused action: no result, no list change.
            end
          endcase
        end
      end

      S_INS_FREE: begin
        // Advance the free list and store the value in the taken entry.
        free_head_next = rd_link;
        free_null_next = rd_null;
        val_we         = 1'b1;
        if (list_null) begin
          link_we        = 1'b1;
          link_waddr     = loc;
          link_wnull     = 1'b1;
          link_widx      = list_head;
          list_head_next = loc;
          list_null_next = 1'b0;
          emit           = 1'b1;
          emit_status    = ST_INSERTED;
          emit_index     = loc;
          state_next     = S_IDLE;
        end else begin
          rd_addr    = list_head;
          state_next = S_INS_HEAD;
        end
      end

      S_INS_HEAD: begin
        if (cmp.lt) begin
          // New head of the list.
          link_we        = 1'b1;
          link_waddr     = loc;
          link_wnull     = 1'b0;
          link_widx      = list_head;
          list_head_next = loc;
          emit           = 1'b1;
          emit_status    = ST_INSERTED;
          emit_index     = loc;
          state_next     = S_IDLE;
        end else begin
          prev_next = list_head;
          if (rd_null) begin
            link_we    = 1'b1;
            link_waddr = loc;
            link_wnull = 1'b1;
            link_widx  = rd_link;
            state_next = S_INS_LINK;
          end else begin
            cur_next   = rd_link;
            rd_addr    = rd_link;
            state_next = S_INS_WALK;
          end
        end
      end

      S_INS_WALK: begin
        if (cmp.lt) begin
          // Link the new entry in front of the larger one.
          link_we    = 1'b1;
          link_waddr = loc;
          link_wnull = 1'b0;
          link_widx  = cur;
          state_next = S_INS_LINK;
        end else begin
          prev_next = cur;
          if (rd_null) begin
            link_we    = 1'b1;
            link_waddr = loc;
            link_wnull = 1'b1;
            link_widx  = rd_link;
            state_next = S_INS_LINK;
          end else begin
            cur_next = rd_link;
            rd_addr  = rd_link;
          end
        end
      end

      S_INS_LINK: begin
        link_we     = 1'b1;
        link_waddr  = prev;
        link_wnull  = 1'b0;
        link_widx   = loc;
        emit        = 1'b1;
        emit_status = ST_INSERTED;
        emit_index  = loc;
        state_next  = S_IDLE;
      end

      S_DEL_HEAD: begin
        if (cmp.eq) begin
          // Unlink the head and push it onto the free list.
          list_head_next = rd_link;
          list_null_next = rd_null;
          link_we        = 1'b1;
          link_waddr     = cur;
          link_wnull     = free_null;
          link_widx      = free_head;
          free_head_next = cur;
          free_null_next = 1'b0;
          emit           = 1'b1;
          emit_status    = ST_DELETED;
          emit_index     = cur;
          state_next     = S_IDLE;
        end else if (rd_null) begin
          emit        = 1'b1;
          emit_status = ST_NOT_FOUND;
          state_next  = S_IDLE;
        end else begin
          prev_next  = cur;
          cur_next   = rd_link;
          rd_addr    = rd_link;
          state_next = S_DEL_WALK;
        end
      end

      S_DEL_WALK: begin
        if (cmp.eq) begin
          // Bridge the predecessor over the matched entry.
          link_we    = 1'b1;
          link_waddr = prev;
          link_wnull = rd_null;
          link_widx  = rd_link;
          state_next = S_DEL_FREE;
        end else if (cmp.lt || rd_null) begin
          emit        = 1'b1;
          emit_status = ST_NOT_FOUND;
          state_next  = S_IDLE;
        end else begin
          prev_next = cur;
          cur_next  = rd_link;
          rd_addr   = rd_link;
        end
      end

      S_DEL_FREE: begin
        link_we        = 1'b1;
        link_waddr     = cur;
        link_wnull     = free_null;
        link_widx      = free_head;
        free_head_next = cur;
        free_null_next = 1'b0;
        emit           = 1'b1;
        emit_status    = ST_DELETED;
        emit_index     = cur;
        state_next     = S_IDLE;
      end

      S_TRV: begin
        // One result per entry; the next read is already on its way.
        emit        = 1'b1;
        emit_status = ST_ENTRY;
        emit_value  = rd_value;
        emit_index  = cur;
        emit_next   = rd_null ? '0 : rd_link;
        emit_null   = rd_null;
        emit_last   = rd_null;
        if (rd_null) begin
          state_next = S_IDLE;
        end else begin
          cur_next = rd_link;
          rd_addr  = rd_link;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      list_head    <= '0;
      list_null    <= 1'b1;
      free_head    <= '0;
      free_null    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      list_head    <= list_head_next;
      list_null    <= list_null_next;
      free_head    <= free_head_next;
      free_null    <= free_null_next;
      result_valid <= emit;
    end
  end

  // Context and result payload: no reset needed.
  always_ff @(posedge clk) begin
    item <= item_next;
    loc  <= loc_next;
    prev <= prev_next;
    cur  <= cur_next;
    if (emit) begin
      status       <= emit_status;
      entry_value  <= emit_value;
      entry_index  <= IDX_OUT_W'(emit_index);
      next_index   <= IDX_OUT_W'(emit_next);
      next_is_null <= emit_null;
      last_result  <= emit_last;
    end
  end

  // A full pool always holds a non-empty list.
  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    free_null |-> !list_null)
    else $error("free list empty while list is empty");

  // Only traverse entries may be followed by more results of the same command.
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status != ST_ENTRY) |-> last_result)
    else $error("non-traverse result not marked last");

  // The tail entry ends the traverse.
  a_tail_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status == ST_ENTRY && next_is_null) |-> last_result)
    else $error("tail entry not marked last");

  // Insert into a full pool answers overflow in the next cycle.
  a_overflow: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action == ACT_INSERT && free_null)
      |=> (result_valid && status == ST_OVERFLOW && !busy))
    else $error("overflow not reported");

  // The block drops busy only together with a final result.
  a_busy_end: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> (result_valid && last_result))
    else $error("operation ended without a final result");

endmodule
